[sv/nghs_pkg.sv]
// ----------------------------------------------------------------------------
// nghs_pkg
// Shared types and constants of the n-gram hash head index session block.
// ----------------------------------------------------------------------------
package nghs_pkg;

    localparam int HEAD_COUNT      = 8;
    localparam int HEADS_PER_NGRAM = 4;
    localparam int STAGED_DEPTH    = 16;

    localparam int HEAD_W   = $clog2(HEAD_COUNT);
    localparam int SADDR_W  = (STAGED_DEPTH > 1) ? $clog2(STAGED_DEPTH) : 1;
    localparam int TOK_W    = 24;
    localparam int VOCAB_W  = 25;
    localparam int MULT_W   = 63;
    localparam int HASH_W   = 64;
    localparam int SIZE_W   = 32;
    localparam int ROW_W    = 35;
    localparam int LIMIT_W  = 5;
    localparam int CNT_W    = 5;
    localparam int DIV_STEPS = HASH_W;
    localparam int DCNT_W   = 7;

    // Register indexes
    localparam logic [2:0] REG_VOCAB_SIZE   = 3'd0;
    localparam logic [2:0] REG_EOS_TOKEN    = 3'd1;
    localparam logic [2:0] REG_MULT_CURRENT = 3'd2;
    localparam logic [2:0] REG_MULT_PREV    = 3'd3;
    localparam logic [2:0] REG_MULT_PREV2   = 3'd4;
    localparam logic [2:0] REG_STAGED_LIMIT = 3'd5;

    typedef enum logic [2:0] {
        KIND_STAGE    = 3'd0,
        KIND_COMMIT   = 3'd1,
        KIND_ROLLBACK = 3'd2,
        KIND_BEGIN    = 3'd3,
        KIND_HEAD_WR  = 3'd4,
        KIND_RESET    = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_STATE = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef struct packed {
        logic [2:0]        kind;
        logic [TOK_W-1:0]  token;
        logic [4:0]        accept_count;
        logic [2:0]        head_index;
        logic [SIZE_W-1:0] head_size;
        logic [ROW_W-1:0]  head_offset;
    } t_in;

    typedef struct packed {
        logic [1:0]       status;
        logic [2:0]       head;
        logic [ROW_W-1:0] row;
        logic             last;
    } t_out;

    // Controller to datapath commands
    typedef struct packed {
        logic              load;
        logic              mul;
        logic [3:0]        mul_cnt;
        logic              div_init;
        logic              div_step;
        logic              div_fin;
        logic [HEAD_W-1:0] head;
        logic              fail;
        logic              stage_ok;
        logic              rd1;
        logic              rd2;
        logic              rd3;
        logic              emit;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic go_stage;
        logic go_rd;
        logic acc_two;
        logic div_err;
    } t_sts;

endpackage

[sv/ngram_hash_head_index_session.sv]
// Flow: a stage beat passes the datapath (multiply steps, then each head in turn on the shared
// one-bit-per-cycle remainder unit, one check), then one result beat per head (one beat on a fail).
// Commit with accepted tokens: the result follows the store reads; other beats go straight to it.
// Throughput: one input beat at a time; the next is taken after the last result beat.
// Reset (i_rst_n low, synchronous): session closed, context and registers to defaults.
// ----------------------------------------------------------------------------
// ngram_hash_head_index_session
// N-gram hash embedding row generator with a speculative token session.
// ----------------------------------------------------------------------------
module ngram_hash_head_index_session (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [2:0]     i_cfg_idx,
    input  logic [62:0]    i_cfg_data,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  nghs_pkg::t_in  i_in,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output nghs_pkg::t_out o_out
);

    nghs_pkg::t_cmd cmd;
    nghs_pkg::t_sts sts;

    // Sequencer
    nghs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Datapath
    nghs_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_out      (o_out)
    );

endmodule

[sv/nghs_ram.sv]
// ----------------------------------------------------------------------------
// nghs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module nghs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/nghs_ctrl.sv]
// ----------------------------------------------------------------------------
// nghs_ctrl
// Sequencer: multiply steps, per-head remainder iterations, commit reads
// and result beats.
// ----------------------------------------------------------------------------
module nghs_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  nghs_pkg::t_sts  i_sts,
    output nghs_pkg::t_cmd  o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_MUL  = 8'b0000_0010,
        S_DIV  = 8'b0000_0100,
        S_CHK  = 8'b0000_1000,
        S_RD1  = 8'b0001_0000,
        S_RD2  = 8'b0010_0000,
        S_RD3  = 8'b0100_0000,
        S_RESP = 8'b1000_0000
    } t_state;

    t_state                      r_state, n_state;
    logic [nghs_pkg::DCNT_W-1:0] r_cnt, n_cnt;
    logic [nghs_pkg::HEAD_W-1:0] r_head, n_head;
    logic                        r_emit, n_emit;

    localparam logic [nghs_pkg::DCNT_W-1:0] CNT_FIN =
        nghs_pkg::DCNT_W'(nghs_pkg::DIV_STEPS + 1);
    localparam logic [nghs_pkg::HEAD_W-1:0] HEAD_LAST =
        nghs_pkg::HEAD_W'(nghs_pkg::HEAD_COUNT - 1);
    localparam logic [nghs_pkg::HEAD_W-1:0] HEAD_ONE = nghs_pkg::HEAD_W'(1);

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_head  = r_head;
        n_emit  = r_emit;
        o_cmd   = '0;
        o_cmd.head    = r_head;
        o_cmd.mul_cnt = r_cnt[3:0];
        o_cmd.emit    = r_emit;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt  = '0;
                    n_head = '0;
                    n_emit = 1'b0;
                    priority if (i_sts.go_stage) begin
                        n_state = S_MUL;
                    end else if (i_sts.go_rd) begin
                        n_state = S_RD1;
                    end else begin
                        n_state = S_RESP;
                    end
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                if (r_cnt == 7'd11) begin
                    n_cnt   = '0;
                    n_state = S_DIV;
                end else begin
                    n_cnt = r_cnt + 7'd1;
                end
            end
            S_DIV: begin
                priority if (r_cnt == '0) begin
                    o_cmd.div_init = 1'b1;
                    n_cnt = r_cnt + 7'd1;
                end else if (r_cnt == CNT_FIN) begin
                    o_cmd.div_fin = 1'b1;
                    n_cnt = '0;
                    if (r_head == HEAD_LAST) begin
                        n_head  = '0;
                        n_state = S_CHK;
                    end else begin
                        n_head = r_head + HEAD_ONE;
                    end
                end else begin
                    o_cmd.div_step = 1'b1;
                    n_cnt = r_cnt + 7'd1;
                end
            end
            S_CHK: begin
                if (i_sts.div_err) begin
                    o_cmd.fail = 1'b1;
                end else begin
                    o_cmd.stage_ok = 1'b1;
                    n_emit = 1'b1;
                end
                n_state = S_RESP;
            end
            S_RD1: begin
                o_cmd.rd1 = 1'b1;
                n_state   = S_RD2;
            end
            S_RD2: begin
                o_cmd.rd2 = 1'b1;
                n_state   = i_sts.acc_two ? S_RD3 : S_RESP;
            end
            S_RD3: begin
                o_cmd.rd3 = 1'b1;
                n_state   = S_RESP;
            end
            S_RESP: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (!r_emit || r_head == HEAD_LAST) begin
                        n_state = S_IDLE;
                        n_head  = '0;
                    end else begin
                        n_head = r_head + HEAD_ONE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_head  <= '0;
            r_emit  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_head  <= n_head;
            r_emit  <= n_emit;
        end
    end

endmodule

[sv/nghs_dp.sv]
// ----------------------------------------------------------------------------
// nghs_dp
// Datapath: configuration, session state, staged store, hash multiplier,
// shared restoring divider and row table.
// ----------------------------------------------------------------------------
module nghs_dp (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [2:0]            i_cfg_idx,
    input  logic [62:0]           i_cfg_data,
    input  nghs_pkg::t_in         i_in,
    input  nghs_pkg::t_cmd        i_cmd,
    output nghs_pkg::t_sts        o_sts,
    output nghs_pkg::t_out        o_out
);

    localparam int TW = nghs_pkg::TOK_W;
    localparam logic [nghs_pkg::ROW_W:0] ROW_MAX = {1'b0, {nghs_pkg::ROW_W{1'b1}}};

    // Configuration
    logic [nghs_pkg::VOCAB_W-1:0] r_vocab;
    logic [TW-1:0]                r_eos;
    logic [nghs_pkg::MULT_W-1:0]  r_mc, r_mp, r_mp2;
    logic [nghs_pkg::LIMIT_W-1:0] r_limit;

    // Session state
    logic                         r_open;
    logic [nghs_pkg::CNT_W-1:0]   r_count;
    logic [TW-1:0]                r_cprev, r_cprev2, r_slast, r_slast2;
    logic [nghs_pkg::SIZE_W-1:0]  r_hsize [nghs_pkg::HEAD_COUNT];
    logic [nghs_pkg::ROW_W-1:0]   r_hoff  [nghs_pkg::HEAD_COUNT];

    // Item and work registers
    logic [4:0]                   r_accept;
    logic [1:0]                   r_status;
    logic [TW-1:0]                r_cur, r_prev, r_older;
    logic [55:0]                  r_pp;
    logic [nghs_pkg::HASH_W-1:0]  r_acc, r_big, r_tri, r_shift;
    logic [nghs_pkg::SIZE_W-1:0]  r_rem;
    logic                         r_err;
    logic [nghs_pkg::ROW_W-1:0]   r_rows [nghs_pkg::HEAD_COUNT];

    // Context of a stage beat
    logic [TW-1:0] ctx_prev, ctx_prev2, ctx_older;
    logic          cap_fail, voc_fail;
    always_comb begin
        ctx_prev  = (r_count >= 5'd1) ? r_slast : r_cprev;
        priority if (r_count >= 5'd2) begin
            ctx_prev2 = r_slast2;
        end else if (r_count == 5'd1) begin
            ctx_prev2 = r_cprev;
        end else begin
            ctx_prev2 = r_cprev2;
        end
        ctx_older = (ctx_prev == r_eos || ctx_prev2 == r_eos) ? r_eos : ctx_prev2;
        cap_fail  = (r_count >= r_limit) ||
                    (32'(r_count) >= nghs_pkg::STAGED_DEPTH);
        voc_fail  = ({1'b0, i_in.token} >= r_vocab) || ({1'b0, ctx_prev} >= r_vocab) ||
                    ({1'b0, ctx_prev2} >= r_vocab);
    end

    // Load decision
    logic [1:0] ld_status;
    logic       ld_stage, ld_rd;
    always_comb begin
        ld_status = nghs_pkg::ST_OK;
        ld_stage  = 1'b0;
        ld_rd     = 1'b0;
        unique case (i_in.kind)
            nghs_pkg::KIND_STAGE: begin
                priority if (!r_open) ld_status = nghs_pkg::ST_STATE;
                else if (cap_fail || voc_fail) ld_status = nghs_pkg::ST_RANGE;
                else ld_stage = 1'b1;
            end
            nghs_pkg::KIND_COMMIT: begin
                priority if (!r_open) ld_status = nghs_pkg::ST_STATE;
                else if (i_in.accept_count > r_count) ld_status = nghs_pkg::ST_RANGE;
                else ld_rd = (i_in.accept_count != 5'd0);
            end
            nghs_pkg::KIND_ROLLBACK: begin
                if (!r_open) ld_status = nghs_pkg::ST_STATE;
            end
            nghs_pkg::KIND_BEGIN: begin
                if (r_open) ld_status = nghs_pkg::ST_STATE;
            end
            nghs_pkg::KIND_HEAD_WR: begin
                if (32'(i_in.head_index) >= nghs_pkg::HEAD_COUNT) begin
                    ld_status = nghs_pkg::ST_RANGE;
                end
            end
            nghs_pkg::KIND_RESET: begin
                if (r_open) ld_status = nghs_pkg::ST_STATE;
            end
            default: ld_status = nghs_pkg::ST_RANGE;
        endcase
    end

    assign o_sts.go_stage = ld_stage;
    assign o_sts.go_rd    = ld_rd;
    assign o_sts.acc_two  = (r_accept >= 5'd2);
    assign o_sts.div_err  = r_err;

    // Multiply step operands
    logic [1:0]                  m_term;
    logic                        m_half;
    logic [TW-1:0]               m_tok;
    logic [nghs_pkg::MULT_W-1:0] m_mult;
    logic [31:0]                 m_op;
    logic [nghs_pkg::HASH_W-1:0] m_prod;
    always_comb begin
        m_term = i_cmd.mul_cnt[3:2];
        m_half = i_cmd.mul_cnt[1];
        unique case (m_term)
            2'd0:    begin m_tok = r_cur;   m_mult = r_mc;  end
            2'd1:    begin m_tok = r_prev;  m_mult = r_mp;  end
            default: begin m_tok = r_older; m_mult = r_mp2; end
        endcase
        m_op   = m_half ? {1'b0, m_mult[62:32]} : m_mult[31:0];
        m_prod = r_acc + {r_pp[31:0], 32'd0};
    end

    // Divider step
    logic [nghs_pkg::HASH_W-1:0] d_hash;
    logic [nghs_pkg::SIZE_W:0]   d_trial;
    logic [nghs_pkg::ROW_W:0]    d_row;
    always_comb begin
        d_hash  = (32'(i_cmd.head) < nghs_pkg::HEADS_PER_NGRAM) ? r_big : r_tri;
        d_trial = {r_rem, r_shift[nghs_pkg::HASH_W-1]};
        d_row   = {1'b0, r_hoff[i_cmd.head]} + {4'd0, r_rem};
    end

    // Staged store
    logic [nghs_pkg::SADDR_W-1:0] ram_raddr;
    logic [TW-1:0]                ram_rdata;
    logic [4:0]                   rd_idx;
    assign rd_idx    = i_cmd.rd1 ? (r_accept - 5'd1) : (r_accept - 5'd2);
    assign ram_raddr = rd_idx[nghs_pkg::SADDR_W-1:0];

    nghs_ram #(
        .WIDTH(TW),
        .DEPTH(nghs_pkg::STAGED_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.stage_ok),
        .i_waddr (r_count[nghs_pkg::SADDR_W-1:0]),
        .i_wdata (r_cur),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Configuration and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vocab  <= 25'h100_0000;
            r_eos    <= '0;
            r_mc     <= 63'd1;
            r_mp     <= 63'd1;
            r_mp2    <= 63'd1;
            r_limit  <= 5'd16;
            r_open   <= 1'b0;
            r_count  <= '0;
            r_cprev  <= '0;
            r_cprev2 <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    nghs_pkg::REG_VOCAB_SIZE:   r_vocab <= i_cfg_data[24:0];
                    nghs_pkg::REG_EOS_TOKEN:    r_eos   <= i_cfg_data[23:0];
                    nghs_pkg::REG_MULT_CURRENT: r_mc    <= i_cfg_data;
                    nghs_pkg::REG_MULT_PREV:    r_mp    <= i_cfg_data;
                    nghs_pkg::REG_MULT_PREV2:   r_mp2   <= i_cfg_data;
                    nghs_pkg::REG_STAGED_LIMIT: r_limit <= i_cfg_data[4:0];
                    default: ;
                endcase
            end
            if (i_cmd.load && ld_status == nghs_pkg::ST_OK) begin
                unique case (i_in.kind)
                    nghs_pkg::KIND_COMMIT, nghs_pkg::KIND_ROLLBACK: begin
                        r_open  <= 1'b0;
                        r_count <= '0;
                    end
                    nghs_pkg::KIND_BEGIN: begin
                        r_open  <= 1'b1;
                        r_count <= '0;
                    end
                    nghs_pkg::KIND_RESET: begin
                        r_cprev  <= r_eos;
                        r_cprev2 <= r_eos;
                        r_count  <= '0;
                    end
                    default: ;
                endcase
            end
            if (i_cmd.stage_ok) begin
                r_count <= r_count + 5'd1;
            end
            // Shift accepted prefix into the committed pair
            if (i_cmd.rd2) begin
                r_cprev <= ram_rdata;
                if (r_accept == 5'd1) begin
                    r_cprev2 <= r_cprev;
                end
            end
            if (i_cmd.rd3) begin
                r_cprev2 <= ram_rdata;
            end
        end
    end

    // Payload and work registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_accept <= i_in.accept_count;
            r_status <= ld_status;
            r_cur    <= i_in.token;
            r_prev   <= ctx_prev;
            r_older  <= ctx_older;
            r_err    <= 1'b0;
            if (i_in.kind == nghs_pkg::KIND_HEAD_WR && ld_status == nghs_pkg::ST_OK) begin
                r_hsize[i_in.head_index[nghs_pkg::HEAD_W-1:0]] <= i_in.head_size;
                r_hoff[i_in.head_index[nghs_pkg::HEAD_W-1:0]]  <= i_in.head_offset;
            end
        end
        if (i_cmd.stage_ok) begin
            r_slast2 <= r_slast;
            r_slast  <= r_cur;
            r_status <= nghs_pkg::ST_OK;
        end
        if (i_cmd.fail) begin
            r_status <= nghs_pkg::ST_RANGE;
        end
        // Multiply then accumulate, one partial product at a time
        if (i_cmd.mul) begin
            if (!i_cmd.mul_cnt[0]) begin
                r_pp <= m_tok * m_op;
            end else if (!m_half) begin
                r_acc <= {8'd0, r_pp};
            end else begin
                unique case (m_term)
                    2'd0:    r_big <= m_prod;
                    2'd1:    r_big <= r_big ^ m_prod;
                    default: r_tri <= r_big ^ m_prod;
                endcase
            end
        end
        // Restoring remainder, one bit per cycle
        if (i_cmd.div_init) begin
            r_shift <= d_hash;
            r_rem   <= '0;
            if (r_hsize[i_cmd.head] == '0) begin
                r_err <= 1'b1;
            end
        end
        if (i_cmd.div_step) begin
            r_shift <= {r_shift[nghs_pkg::HASH_W-2:0], 1'b0};
            if (d_trial >= {1'b0, r_hsize[i_cmd.head]}) begin
                r_rem <= nghs_pkg::SIZE_W'(d_trial - {1'b0, r_hsize[i_cmd.head]});
            end else begin
                r_rem <= d_trial[nghs_pkg::SIZE_W-1:0];
            end
        end
        if (i_cmd.div_fin) begin
            r_rows[i_cmd.head] <= d_row[nghs_pkg::ROW_W-1:0];
            if (d_row > ROW_MAX) begin
                r_err <= 1'b1;
            end
        end
    end

    // Result beat
    always_comb begin
        o_out.status = r_status;
        o_out.head   = i_cmd.emit ? i_cmd.head : '0;
        o_out.row    = i_cmd.emit ? r_rows[i_cmd.head] : '0;
        o_out.last   = !i_cmd.emit ||
                       (32'(i_cmd.head) == nghs_pkg::HEAD_COUNT - 1);
    end

endmodule

[verif/ngram_hash_head_index_session_chk.sv]
// ----------------------------------------------------------------------------
// ngram_hash_head_index_session_chk
// Watches the configuration, input and result channels of the n-gram hash
// session block, predicts every result beat and compares it field by field.
// ----------------------------------------------------------------------------
module ngram_hash_head_index_session_chk
    import nghs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [62:0] i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  t_in         i_in,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  t_out        i_out,
    output int          o_pending,
    output int          o_errors
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] ROW_LIMIT = 64'h7_FFFF_FFFF;

    // Register copies
    logic [VOCAB_W-1:0] vocab;
    logic [TOK_W-1:0]   eos;
    logic [MULT_W-1:0]  m_cur, m_prev, m_prev2;
    logic [LIMIT_W-1:0] limit;

    // Session state copies
    logic               open_txn;
    logic [TOK_W-1:0]   staged [STAGED_DEPTH];
    int                 staged_n;
    logic [TOK_W-1:0]   ctx_prev, ctx_prev2;
    logic [SIZE_W-1:0]  head_size [HEAD_COUNT];
    logic [ROW_W-1:0]   head_offs [HEAD_COUNT];

    t_out expected_rows [$];
    int   errors;

    assign o_pending = expected_rows.size();
    assign o_errors  = errors;

    // Append one expected beat
    function automatic void queue_beat(t_out e);
        expected_rows = {expected_rows, e};
    endfunction

    function automatic void push_status(t_status s);
        t_out e;
        e        = '0;
        e.status = s;
        e.last   = 1'b1;
        queue_beat(e);
    endfunction

    // Build the context, hash and per-head rows for one staged token
    function automatic void predict_stage(logic [TOK_W-1:0] tok);
        logic [TOK_W-1:0] p1, p2, older;
        logic [63:0]      bigram, trigram, hsh, row;
        logic [63:0]      rows [HEAD_COUNT];
        logic             bad;
        t_out             e;
        bad = 1'b0;
        if (!open_txn) begin
            push_status(ST_STATE);
            return;
        end
        if (staged_n >= int'(limit) || staged_n >= STAGED_DEPTH) begin
            push_status(ST_RANGE);
            return;
        end
        p1 = (staged_n >= 1) ? staged[staged_n-1] : ctx_prev;
        if (staged_n >= 2)
            p2 = staged[staged_n-2];
        else if (staged_n == 1)
            p2 = ctx_prev;
        else
            p2 = ctx_prev2;
        if ({1'b0, tok} >= vocab || {1'b0, p1} >= vocab || {1'b0, p2} >= vocab) begin
            push_status(ST_RANGE);
            return;
        end
        older   = (p1 == eos || p2 == eos) ? eos : p2;
        bigram  = (64'(tok) * 64'(m_cur)) ^ (64'(p1) * 64'(m_prev));
        trigram = bigram ^ (64'(older) * 64'(m_prev2));
        for (int h = 0; h < HEAD_COUNT; h++) begin
            hsh = (h < HEADS_PER_NGRAM) ? bigram : trigram;
            if (head_size[h] == '0) begin
                bad = 1'b1;
            end else begin
                row = 64'(head_offs[h]) + hsh % 64'(head_size[h]);
                if (row > ROW_LIMIT)
                    bad = 1'b1;
                rows[h] = row;
            end
        end
        if (bad) begin
            push_status(ST_RANGE);
            return;
        end
        staged[staged_n] = tok;
        staged_n++;
        for (int h = 0; h < HEAD_COUNT; h++) begin
            e        = '0;
            e.status = ST_OK;
            e.head   = 3'(h);
            e.row    = rows[h][ROW_W-1:0];
            e.last   = (h == HEAD_COUNT - 1);
            queue_beat(e);
        end
    endfunction

    function automatic void predict(t_in it);
        case (it.kind)
            KIND_STAGE: predict_stage(it.token);
            KIND_COMMIT: begin
                if (!open_txn)
                    push_status(ST_STATE);
                else if (int'(it.accept_count) > staged_n)
                    push_status(ST_RANGE);
                else begin
                    for (int i = 0; i < int'(it.accept_count); i++) begin
                        ctx_prev2 = ctx_prev;
                        ctx_prev  = staged[i];
                    end
                    staged_n = 0;
                    open_txn = 1'b0;
                    push_status(ST_OK);
                end
            end
            KIND_ROLLBACK: begin
                if (!open_txn)
                    push_status(ST_STATE);
                else begin
                    staged_n = 0;
                    open_txn = 1'b0;
                    push_status(ST_OK);
                end
            end
            KIND_BEGIN: begin
                if (open_txn)
                    push_status(ST_STATE);
                else begin
                    staged_n = 0;
                    open_txn = 1'b1;
                    push_status(ST_OK);
                end
            end
            KIND_HEAD_WR: begin
                head_size[it.head_index] = it.head_size;
                head_offs[it.head_index] = it.head_offset;
                push_status(ST_OK);
            end
            KIND_RESET: begin
                if (open_txn)
                    push_status(ST_STATE);
                else begin
                    ctx_prev  = eos;
                    ctx_prev2 = eos;
                    staged_n  = 0;
                    push_status(ST_OK);
                end
            end
            default: push_status(ST_RANGE);
        endcase
    endfunction

    // Track registers, predict on input beats, compare on result beats
    always @(posedge i_clk) begin
        t_out e;
        if (!i_rst_n) begin
            vocab     <= 25'd16777216;
            eos       <= '0;
            m_cur     <= 63'd1;
            m_prev    <= 63'd1;
            m_prev2   <= 63'd1;
            limit     <= 5'd16;
            open_txn  <= 1'b0;
            staged_n  <= 0;
            ctx_prev  <= '0;
            ctx_prev2 <= '0;
            expected_rows.delete();
            errors    <= 0;
            for (int h = 0; h < HEAD_COUNT; h++) begin
                head_size[h] <= '0;
                head_offs[h] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_VOCAB_SIZE:   vocab   <= i_cfg_data[VOCAB_W-1:0];
                    REG_EOS_TOKEN:    eos     <= i_cfg_data[TOK_W-1:0];
                    REG_MULT_CURRENT: m_cur   <= i_cfg_data;
                    REG_MULT_PREV:    m_prev  <= i_cfg_data;
                    REG_MULT_PREV2:   m_prev2 <= i_cfg_data;
                    REG_STAGED_LIMIT: limit   <= i_cfg_data[LIMIT_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                predict(i_in);
            if (i_out_valid && i_out_ready) begin
                if (expected_rows.size() == 0) begin
                    if (errors < 10)
                        $display("ERROR: unexpected result beat status=%0d head=%0d row=%0h last=%0b",
                                 i_out.status, i_out.head, i_out.row, i_out.last);
                    errors <= errors + 1;
                end else begin
                    e = expected_rows.pop_front();
                    if (i_out.status !== e.status || i_out.head !== e.head ||
                        i_out.row !== e.row || i_out.last !== e.last) begin
                        if (errors < 10)
                            $display("ERROR: exp status=%0d head=%0d row=%0h last=%0b, got status=%0d head=%0d row=%0h last=%0b",
                                     e.status, e.head, e.row, e.last,
                                     i_out.status, i_out.head, i_out.row, i_out.last);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end

endmodule

[verif/ngram_hash_head_index_session_tb.sv]
// ----------------------------------------------------------------------------
// ngram_hash_head_index_session_tb
// Drives directed session cases and random begin/stage/commit or rollback sequences under
// several register settings, with random idling on both channels; the checker
// beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module ngram_hash_head_index_session_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import nghs_pkg::*;

    localparam int TARGET_ITEMS = 270;
    localparam int STALL_LIMIT  = 20000;
    localparam int IN_W         = $bits(t_in);

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_idx = '0;
    logic [62:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    t_in         in_beat = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    t_out        out_beat;
    int          pending, errors;
    int          sent;
    bit          quiet;
    int          stall_left;
    int          idle_cycles;
    logic [VOCAB_W-1:0] cur_vocab;
    logic [TOK_W-1:0]   cur_eos;
    int                 cur_limit;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    ngram_hash_head_index_session u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_beat)
    );

    ngram_hash_head_index_session_chk u_chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in        (in_beat),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out       (out_beat),
        .o_pending   (pending),
        .o_errors    (errors)
    );

    // Result side: random stall bursts, none in the quiet tail
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready  <= 1'b0;
            stall_left <= 0;
        end else if (quiet) begin
            out_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end else if ($urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(0, 13);
            out_ready  <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // Abort when no beat moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // Drop valid for a burst of idle cycles
    task automatic sender_gap(int n);
        if (n > 0) begin
            in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Present one beat and hold it until accepted
    task automatic send(t_in it);
        if (!quiet && $urandom_range(0, 6) == 0)
            sender_gap($urandom_range(1, 14));
        in_valid <= 1'b1;
        in_beat  <= it;
        do @(posedge i_clk); while (!in_ready);
        sent++;
    endtask

    task automatic send_kind(t_kind k, logic [TOK_W-1:0] tok, logic [4:0] acc);
        t_in it;
        it              = '0;
        it.kind         = k;
        it.token        = tok;
        it.accept_count = acc;
        send(it);
    endtask

    task automatic write_head(int h, logic [SIZE_W-1:0] sz, logic [ROW_W-1:0] off);
        t_in it;
        it             = '0;
        it.kind        = KIND_HEAD_WR;
        it.head_index  = 3'(h);
        it.head_size   = sz;
        it.head_offset = off;
        send(it);
    endtask

    // Head entry that never overflows a row
    task automatic write_sane_head(int h);
        logic [ROW_W-1:0] off;
        off = {1'b0, 2'($urandom), 32'($urandom)};
        write_head(h, ($urandom_range(0, 1) == 0) ? SIZE_W'($urandom_range(2, 1000))
                                                  : SIZE_W'($urandom_range(2, 32'hFFFF_FFFF)),
                   off);
    endtask

    // Hold the sender until every result beat is back
    task automatic drain();
        sender_gap(1);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_regs(logic [24:0] voc, logic [23:0] eo, logic [62:0] mc,
                              logic [62:0] mp, logic [62:0] mp2, int lim);
        logic [62:0] vals [6];
        vals = '{63'(voc), 63'(eo), mc | 63'd1, mp | 63'd1, mp2 | 63'd1, 63'(lim)};
        drain();
        for (int i = 0; i < 6; i++) begin
            cfg_we   <= 1'b1;
            cfg_idx  <= 3'(i);
            cfg_data <= vals[i];
            @(posedge i_clk);
        end
        cfg_we    <= 1'b0;
        cur_vocab = voc;
        cur_eos   = eo;
        cur_limit = lim;
    endtask

    function automatic logic [TOK_W-1:0] pick_token();
        if ($urandom_range(0, 9) == 0)
            return TOK_W'($urandom);
        if ({1'b0, cur_eos} < cur_vocab && $urandom_range(0, 6) == 0)
            return cur_eos;
        return TOK_W'($urandom_range(0, int'(cur_vocab) - 1));
    endfunction

    function automatic logic [62:0] rand_mult();
        return {31'($urandom), 32'($urandom)};
    endfunction

    // One well-formed session with random content, or a noise beat
    task automatic random_item();
        t_in it;
        int  n;
        if ($urandom_range(0, 4) == 0) begin
            it = IN_W'({$urandom, $urandom, $urandom, $urandom});
            if ($urandom_range(0, 1) == 0)
                it.head_offset = {1'b0, it.head_offset[33:0]};
            send(it);
            return;
        end
        if ($urandom_range(0, 3) == 0)
            write_sane_head($urandom_range(0, HEAD_COUNT - 1));
        if ($urandom_range(0, 5) == 0)
            send_kind(KIND_RESET, '0, '0);
        send_kind(KIND_BEGIN, '0, '0);
        n = $urandom_range(0, cur_limit + 1);
        for (int i = 0; i < n; i++)
            send_kind(KIND_STAGE, pick_token(), '0);
        if ($urandom_range(0, 4) == 0)
            send_kind(KIND_ROLLBACK, '0, '0);
        else
            send_kind(KIND_COMMIT, '0, 5'($urandom_range(0, (n > 16 ? 16 : n) + 1)));
    endtask

    initial begin
        quiet = 1'b0;
        sent  = 0;
        cur_vocab = 25'd16777216;
        cur_eos   = '0;
        cur_limit = 16;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Load every head before any stage can read it
        write_head(0, 32'd2, '0);
        write_head(1, 32'hFFFF_FFFF, 35'd7);
        for (int h = 2; h < HEAD_COUNT; h++)
            write_sane_head(h);

        // Directed: session errors, unknown kinds, limits and special cases
        send_kind(KIND_STAGE, 24'd5, '0);
        send_kind(KIND_COMMIT, '0, 5'd0);
        send_kind(KIND_ROLLBACK, '0, '0);
        send_kind(t_kind'(3'd6), '0, '0);
        send_kind(t_kind'(3'd7), 24'hFFFFFF, 5'h1F);
        send_kind(KIND_BEGIN, '0, '0);
        send_kind(KIND_BEGIN, '0, '0);
        send_kind(KIND_STAGE, 24'hFFFFFF, '0);
        send_kind(KIND_STAGE, 24'd0, '0);
        send_kind(KIND_RESET, '0, '0);
        send_kind(KIND_COMMIT, '0, 5'd16);
        send_kind(KIND_COMMIT, '0, 5'd2);
        send_kind(KIND_RESET, '0, '0);
        send_kind(KIND_BEGIN, '0, '0);
        write_head(3, 32'd0, 35'd0);
        send_kind(KIND_STAGE, 24'd9, '0);
        write_head(3, 32'd5, 35'h7_FFFF_FFFF);
        send_kind(KIND_STAGE, 24'd9, '0);
        write_sane_head(3);
        send_kind(KIND_STAGE, 24'd9, '0);
        send_kind(KIND_ROLLBACK, '0, '0);

        // Register settings, extremes first, then random ones
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: write_regs(25'd1, 24'd0, 63'd1, 63'd1, 63'd1, 1);
                1: write_regs(25'd16777216, 24'hFFFFFF, '1, '1, '1, 16);
                2: write_regs(25'd64, 24'd3, rand_mult(), rand_mult(), rand_mult(), 3);
                3: write_regs(25'($urandom_range(1, 16777216)), 24'($urandom),
                              rand_mult(), rand_mult(), rand_mult(), $urandom_range(1, 16));
                4: write_regs(25'd16777216, 24'd0, rand_mult(), rand_mult(), rand_mult(), 16);
                default: write_regs(25'd1000, 24'd7, rand_mult(), rand_mult(), rand_mult(),
                                    $urandom_range(1, 16));
            endcase
            if (ph == 5)
                quiet = 1'b1;
            while (sent < TARGET_ITEMS * (ph + 1) / 6)
                random_item();
        end

        sender_gap(1);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

[ngram_hash_head_index_session.f]
sv/nghs_pkg.sv
sv/nghs_ram.sv
sv/nghs_ctrl.sv
sv/nghs_dp.sv
sv/ngram_hash_head_index_session.sv
verif/ngram_hash_head_index_session_chk.sv
verif/ngram_hash_head_index_session_tb.sv
